// ----- design/rhd_pkg.sv -----
// ----------------------------------------------------------------------------
// rhd_pkg
// Types, codes and helpers shared by the H.264 RTP depacketizer modules.
// ----------------------------------------------------------------------------
package rhd_pkg;

    // One payload byte as it arrives on the input channel.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_in_packet;
        logic       empty_packet;
    } in_beat_t;

    // One result beat on the output channel.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] nal_byte;
        logic [4:0] unit_type;
        logic       from_fragment;
        logic       unit_first;
        logic       unit_last;
        logic       discard;
        logic [1:0] error_code;
    } out_beat_t;

    // Up to two result beats produced by one payload byte.
    typedef struct packed {
        logic [1:0] count;
        out_beat_t  beat0;
        out_beat_t  beat1;
    } push_t;

    // NAL types.
    localparam logic [4:0] NAL_STAP_A = 5'd24;
    localparam logic [4:0] NAL_FU_A   = 5'd28;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_EMPTY    = 2'd1;
    localparam logic [1:0] ERR_SHORT_FU = 2'd2;

    // Position of a byte within its payload.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    // Packet kind, taken from the first payload byte.
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_STAP   = 2'd1;
    localparam logic [1:0] MODE_FU     = 2'd2;

    // STAP-A parsing phase.
    localparam logic [1:0] PH_SIZE_HI    = 2'd0;
    localparam logic [1:0] PH_SIZE_LO    = 2'd1;
    localparam logic [1:0] PH_UNIT_FIRST = 2'd2;
    localparam logic [1:0] PH_UNIT_MORE  = 2'd3;

    // Depth of the result queue.
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);

    // Builds one result beat from its fields.
    function automatic out_beat_t make_beat(
        input logic       has,
        input logic [7:0] data,
        input logic [4:0] ntype,
        input logic       frag,
        input logic       first,
        input logic       last,
        input logic       disc,
        input logic [1:0] err
    );
        out_beat_t r;
        r.has_byte      = has;
        r.nal_byte      = data;
        r.unit_type     = ntype;
        r.from_fragment = frag;
        r.unit_first    = first;
        r.unit_last     = last;
        r.discard       = disc;
        r.error_code    = err;
        return r;
    endfunction

endpackage

// ----- design/rhd_core.sv -----
// ----------------------------------------------------------------------------
// rhd_core
// Packet parsing state and the per-byte step logic of the depacketizer.
// ----------------------------------------------------------------------------
module rhd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  rhd_pkg::in_beat_t item,
    output rhd_pkg::push_t    push
);
    import rhd_pkg::*;

    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  size_hi_reg, size_hi_next;
    logic [15:0] remain_reg, remain_next;
    logic [4:0]  dtype_reg, dtype_next;
    logic [2:0]  ind_reg, ind_next;
    logic [4:0]  ftype_reg, ftype_next;
    logic        fopen_reg, fopen_next;
    logic        fend_reg, fend_next;

    // Parsing state registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg     <= POS_FIRST;
            mode_reg    <= MODE_SINGLE;
            phase_reg   <= PH_SIZE_HI;
            size_hi_reg <= '0;
            remain_reg  <= '0;
            dtype_reg   <= '0;
            ind_reg     <= '0;
            ftype_reg   <= '0;
            fopen_reg   <= 1'b0;
            fend_reg    <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            size_hi_reg <= size_hi_next;
            remain_reg  <= remain_next;
            dtype_reg   <= dtype_next;
            ind_reg     <= ind_next;
            ftype_reg   <= ftype_next;
            fopen_reg   <= fopen_next;
            fend_reg    <= fend_next;
        end
    end

    // One step of the parser for the byte in the input register.
    always_comb begin
        logic [7:0]  b;
        logic        last;
        logic        disc;
        logic        close;
        logic        first;
        logic        done;
        logic [4:0]  ut;
        logic [15:0] dec;
        logic [15:0] size;

        b    = item.payload_byte;
        last = item.last_in_packet;
        disc = 1'b0;
        close = 1'b0;
        first = 1'b0;
        done = 1'b0;
        ut   = '0;
        dec  = remain_reg - 16'd1;
        size = {size_hi_reg, b};

        pos_next     = pos_reg;
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        size_hi_next = size_hi_reg;
        remain_next  = remain_reg;
        dtype_next   = dtype_reg;
        ind_next     = ind_reg;
        ftype_next   = ftype_reg;
        fopen_next   = fopen_reg;
        fend_next    = fend_reg;

        push.count = 2'd0;
        push.beat0 = '0;
        push.beat1 = '0;

        if (fire) begin
            if (item.empty_packet) begin
                // Empty payload: report it and drop any cut-short direct unit.
                disc = (pos_reg != POS_FIRST) &&
                       ((mode_reg == MODE_SINGLE) || ((mode_reg == MODE_STAP) && phase_reg[1]));
                push.beat0 = make_beat(1'b0, 8'd0, disc ? dtype_reg : 5'd0, 1'b0, 1'b0, 1'b0,
                                       disc, ERR_EMPTY);
                push.count  = 2'd1;
                pos_next    = POS_FIRST;
                mode_next   = MODE_SINGLE;
                phase_next  = PH_SIZE_HI;
                remain_next = '0;
                fend_next   = 1'b0;
            end else begin
                if (pos_reg == POS_FIRST) begin
                    // Payload header byte selects the packet kind.
                    ut          = b[4:0];
                    fend_next   = 1'b0;
                    phase_next  = PH_SIZE_HI;
                    remain_next = '0;
                    if (ut == NAL_STAP_A) begin
                        mode_next = MODE_STAP;
                    end else if (ut == NAL_FU_A) begin
                        mode_next = MODE_FU;
                        ind_next  = b[7:5];
                        if (last) begin
                            push.beat0 = make_beat(1'b0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                                   ERR_SHORT_FU);
                            push.count = 2'd1;
                        end
                    end else begin
                        mode_next  = MODE_SINGLE;
                        dtype_next = ut;
                        push.beat0 = make_beat(1'b1, b, ut, 1'b0, 1'b1, last, 1'b0, ERR_NONE);
                        push.count = 2'd1;
                    end
                end else if (mode_reg == MODE_SINGLE) begin
                    // Single NAL unit body.
                    push.beat0 = make_beat(1'b1, b, dtype_reg, 1'b0, 1'b0, last, 1'b0, ERR_NONE);
                    push.count = 2'd1;
                end else if (mode_reg == MODE_STAP) begin
                    // Aggregation packet: size fields and unit bytes.
                    case (phase_reg)
                        PH_SIZE_HI: begin
                            size_hi_next = b;
                            phase_next   = PH_SIZE_LO;
                        end
                        PH_SIZE_LO: begin
                            remain_next = size;
                            phase_next  = (size != 16'd0) ? PH_UNIT_FIRST : PH_SIZE_HI;
                        end
                        default: begin
                            first = (phase_reg == PH_UNIT_FIRST);
                            ut    = first ? b[4:0] : dtype_reg;
                            dtype_next  = ut;
                            remain_next = dec;
                            done        = (dec == 16'd0);
                            push.beat0  = make_beat(1'b1, b, ut, 1'b0, first, done, 1'b0,
                                                    ERR_NONE);
                            push.count  = 2'd1;
                            phase_next  = done ? PH_SIZE_HI : PH_UNIT_MORE;
                            if (last && !done) begin
                                push.beat1  = make_beat(1'b0, 8'd0, ut, 1'b0, 1'b0, 1'b0, 1'b1,
                                                        ERR_NONE);
                                push.count  = 2'd2;
                                phase_next  = PH_SIZE_HI;
                                remain_next = '0;
                            end
                        end
                    endcase
                end else if (pos_reg == POS_SECOND) begin
                    // FU header: start and end bits plus the unit type.
                    fend_next = b[6];
                    if (b[7]) begin
                        close      = last && b[6];
                        ftype_next = b[4:0];
                        fopen_next = !close;
                        if (fopen_reg) begin
                            push.beat0 = make_beat(1'b0, 8'd0, ftype_reg, 1'b1, 1'b0, 1'b0,
                                                   1'b1, ERR_NONE);
                            push.beat1 = make_beat(1'b1, {ind_reg, b[4:0]}, b[4:0], 1'b1,
                                                   1'b1, close, 1'b0, ERR_NONE);
                            push.count = 2'd2;
                        end else begin
                            push.beat0 = make_beat(1'b1, {ind_reg, b[4:0]}, b[4:0], 1'b1,
                                                   1'b1, close, 1'b0, ERR_NONE);
                            push.count = 2'd1;
                        end
                    end else if (fopen_reg && last && b[6]) begin
                        push.beat0 = make_beat(1'b0, 8'd0, ftype_reg, 1'b1, 1'b0, 1'b1, 1'b0,
                                               ERR_NONE);
                        push.count = 2'd1;
                        fopen_next = 1'b0;
                    end
                end else if (fopen_reg) begin
                    // Fragment body byte.
                    close      = last && fend_reg;
                    push.beat0 = make_beat(1'b1, b, ftype_reg, 1'b1, 1'b0, close, 1'b0,
                                           ERR_NONE);
                    push.count = 2'd1;
                    if (close) begin
                        fopen_next = 1'b0;
                    end
                end

                // Track the byte position within the payload.
                if (last) begin
                    pos_next = POS_FIRST;
                end else if (pos_reg == POS_FIRST) begin
                    pos_next = POS_SECOND;
                end else begin
                    pos_next = POS_LATER;
                end
            end
        end
    end

endmodule

// ----- design/rhd_result_fifo.sv -----
// ----------------------------------------------------------------------------
// rhd_result_fifo
// Small result queue: takes up to two beats per cycle, gives out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module rhd_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  rhd_pkg::push_t     push,
    output logic [rhd_pkg::RES_AW:0] level,
    output logic               valid,
    input  logic               stall,
    output rhd_pkg::out_beat_t data
);
    import rhd_pkg::*;

    out_beat_t         mem [RES_DEPTH];
    logic [RES_AW-1:0] wr_reg, wr_next;
    logic [RES_AW-1:0] rd_reg, rd_next;
    logic [RES_AW:0]   cnt_reg, cnt_next;
    logic              pop;

    assign pop   = valid && !stall;
    assign valid = (cnt_reg != '0);
    assign data  = mem[rd_reg];
    assign level = cnt_reg;

    // Pointer and fill count update.
    always_comb begin
        wr_next  = wr_reg + RES_AW'(push.count);
        rd_next  = rd_reg + RES_AW'(pop);
        cnt_next = cnt_reg + (RES_AW + 1)'(push.count) - (RES_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage writes, one or two entries per cycle.
    always_ff @(posedge clk) begin
        if (push.count != 2'd0) begin
            mem[wr_reg] <= push.beat0;
        end
        if (push.count == 2'd2) begin
            mem[wr_reg + RES_AW'(1)] <= push.beat1;
        end
    end

endmodule

// ----- design/rtp_h264_depacketizer.sv -----
// ----------------------------------------------------------------------------
// rtp_h264_depacketizer
// H.264 RTP payload depacketizer: single NAL, STAP-A and FU-A packets.
// ----------------------------------------------------------------------------
// Input channel: one payload byte per beat with a last-of-packet mark, or a
// beat marked empty that stands for an empty payload. Output channel: one
// result beat per handshake with the unit byte, its NAL type and the
// first, last, discard, fragment and error marks.
// A byte is taken into an input register, and the parser step then turns it
// into zero, one or two result beats that go into a four-entry result
// queue. The output is read straight from the queue, so a result can be
// taken as soon as it has been written there.
// Throughput is one byte per cycle as long as each byte makes at most one
// result and the receiver does not stall; a byte that makes two results (a
// cut STAP-A unit, a new FU start over an open fragment) queues an extra beat.
// The input register advances whenever the queue holds at most two beats.
// When the receiver stalls, results wait in the queue, and the input stalls
// once the queue holds more than two beats; nothing is dropped. Reset
// clears the parser state and empties both the input register and the queue.
// ----------------------------------------------------------------------------
module rtp_h264_depacketizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rhd_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rhd_pkg::out_beat_t out_data
);
    import rhd_pkg::*;

    in_beat_t        item_reg;
    logic            full_reg, full_next;
    logic            advance;
    logic            take;
    logic [RES_AW:0] level;
    push_t           push;

    // The held byte moves on when the queue has room for two beats.
    assign advance  = full_reg && (level <= (RES_AW + 1)'(RES_DEPTH - 2));
    assign in_stall = full_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        full_next = take ? 1'b1 : (advance ? 1'b0 : full_reg);
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_data;
        end
    end

    // Parser step.
    rhd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .push  (push)
    );

    // Result queue and output channel.
    rhd_result_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .level (level),
        .valid (out_valid),
        .stall (out_stall),
        .data  (out_data)
    );

endmodule
